>>> hw/rtl/sound_voice_allocator_defines.svh
// Assertion helpers used by the voice allocator top level.
// The macros expect signals named clk and rst_n in the enclosing module.
`ifndef SOUND_VOICE_ALLOCATOR_DEFINES_SVH
`define SOUND_VOICE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

`define SVA_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define SVA_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define SVA_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define SVA_IMPLIES(label, ante, cons)
`define SVA_NEXT(label, ante, cons)
`define SVA_NEVER(label, cond)

`endif

`endif

>>> hw/rtl/sva_pkg.sv
package sva_pkg;

  // config register indexes
  localparam logic [1:0] CFG_MIN_VOLUME_GAP   = 2'd0;
  localparam logic [1:0] CFG_MIN_REPEAT_DELAY = 2'd1;
  localparam logic [1:0] CFG_MAX_SAME_CLIP    = 2'd2;

  localparam logic [7:0]  GAP_RESET      = 8'd16;
  localparam logic [15:0] DELAY_RESET    = 16'd50;
  localparam logic [6:0]  MAX_SAME_RESET = 7'd2;

  typedef struct packed {
    logic [7:0]  min_volume_gap;
    logic [15:0] min_repeat_delay;
    logic [6:0]  max_same_clip;
  } cfg_t;

  typedef struct packed {
    logic [15:0] clip_id;
    logic [7:0]  volume;
    logic [31:0] now_ms;
  } req_t;

  // request token walking down the channel cells
  typedef struct packed {
    logic        valid;
    req_t        req;
    logic        suppress;
    logic [31:0] oldest_time;
  } probe_t;

endpackage

>>> hw/rtl/sva_cell.sv
module sva_cell
  import sva_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  probe_t        probe_i,
  input  logic [CW-1:0] count_i,
  input  logic [IW-1:0] oldest_i,
  output probe_t        probe_o,
  output logic [CW-1:0] count_o,
  output logic [IW-1:0] oldest_o,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_sel,
  input  req_t          wr_req
);

  logic [15:0]   clip_r;
  logic [7:0]    vol_r;
  logic [31:0]   start_r;

  probe_t        probe_r, probe_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] oldest_r, oldest_nxt;

  logic          match;
  logic [7:0]    vol_diff;
  logic [31:0]   age;
  logic          hit;
  logic          take;

  always_comb begin
    match    = (clip_r == probe_i.req.clip_id);
    vol_diff = (vol_r > probe_i.req.volume) ? (vol_r - probe_i.req.volume)
                                             : (probe_i.req.volume - vol_r);
    age      = probe_i.req.now_ms - start_r;
    hit      = match && (vol_diff < cfg.min_volume_gap)
                     && (age < 32'(cfg.min_repeat_delay));
    // oldest by raw start time, ties go to the lower channel
    take     = match && ((count_i == '0) || (probe_i.oldest_time > start_r));

    probe_nxt          = probe_i;
    probe_nxt.suppress = probe_i.suppress | hit;
    if (take) begin
      probe_nxt.oldest_time = start_r;
    end
    count_nxt  = count_i + CW'(match);
    oldest_nxt = take ? IW'(INDEX) : oldest_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
    count_r  <= count_nxt;
    oldest_r <= oldest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r  <= '0;
      vol_r   <= '0;
      start_r <= '0;
    end else if (wr_en && (wr_sel == IW'(INDEX))) begin
      clip_r  <= wr_req.clip_id;
      vol_r   <= wr_req.volume;
      start_r <= wr_req.now_ms;
    end
  end

  assign probe_o  = probe_r;
  assign count_o  = count_r;
  assign oldest_o = oldest_r;

endmodule

>>> hw/rtl/sound_voice_allocator.sv
// Sound voice allocator.
// Input stream: one beat per play request, tdata = {now_ms, volume, clip_id}.
// Output stream: one beat per request, tdata = {stole_same_clip, channel, started}.
// Config port: cfg_wr_en with cfg_index selects gap (0), repeat delay (1) or
// same-clip limit (2); other indexes are ignored. Write only while idle.
// Each channel lives in a cell of a chain; an accepted request walks the chain
// one cell per cycle, collecting suppression, same-clip count and the oldest
// matching channel. After the last cell the channel is chosen and held in a
// pending register; when the output register is free, the choice is written
// back and the result beat presented. One request is in flight at a time:
// in_tready drops on accept and returns in the same cycle that the result
// beat is registered, so a new request is taken only once the previous one
// has left the cell chain and been committed.
// A finished result may sit in the output register while the next request is
// accepted; if the receiver stalls, the next result waits at the chain end.
// Reset clears all channels to empty (clip 0, volume 0, start 0), sets the
// round-robin pointer to 0 and loads default config values.
`include "sound_voice_allocator_defines.svh"

module sound_voice_allocator
  import sva_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // clip_id[15:0], volume[23:16], now_ms[55:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // started[0], channel[6:1], stole_same_clip[7]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);

  cfg_t          cfg_r;
  logic          busy_r;
  logic [IW-1:0] next_ch_r;

  logic          pend_valid_r;
  logic          pend_started_r;
  logic          pend_stole_r;
  logic [IW-1:0] pend_target_r;
  req_t          pend_req_r;

  logic          out_valid_r;
  logic [7:0]    out_data_r;

  probe_t        probe_w  [0:CHANNELS];
  logic [CW-1:0] count_w  [0:CHANNELS];
  logic [IW-1:0] oldest_w [0:CHANNELS];

  logic          accept;
  logic          commit;
  probe_t        tail;
  logic          round_robin;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign commit    = pend_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    probe_w[0].valid          = accept;
    probe_w[0].req.clip_id    = in_tdata[15:0];
    probe_w[0].req.volume     = in_tdata[23:16];
    probe_w[0].req.now_ms     = in_tdata[55:24];
    probe_w[0].suppress       = 1'b0;
    probe_w[0].oldest_time    = '0;
    count_w[0]                = '0;
    oldest_w[0]               = '0;
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    sva_cell #(
      .INDEX (g),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg_r),
      .probe_i  (probe_w[g]),
      .count_i  (count_w[g]),
      .oldest_i (oldest_w[g]),
      .probe_o  (probe_w[g+1]),
      .count_o  (count_w[g+1]),
      .oldest_o (oldest_w[g+1]),
      .wr_en    (commit && pend_started_r),
      .wr_sel   (pend_target_r),
      .wr_req   (pend_req_r)
    );
  end

  assign tail        = probe_w[CHANNELS];
  assign round_robin = (8'(count_w[CHANNELS]) <= 8'(cfg_r.max_same_clip));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_volume_gap   <= GAP_RESET;
      cfg_r.min_repeat_delay <= DELAY_RESET;
      cfg_r.max_same_clip    <= MAX_SAME_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_VOLUME_GAP:   cfg_r.min_volume_gap   <= cfg_wdata[7:0];
        CFG_MIN_REPEAT_DELAY: cfg_r.min_repeat_delay <= cfg_wdata;
        CFG_MAX_SAME_CLIP:    cfg_r.max_same_clip    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // decision at the end of the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (tail.valid) begin
      pend_valid_r <= 1'b1;
    end else if (commit) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      pend_req_r <= tail.req;
      if (tail.suppress) begin
        pend_started_r <= 1'b0;
        pend_stole_r   <= 1'b0;
        pend_target_r  <= '0;
      end else if (round_robin) begin
        pend_started_r <= 1'b1;
        pend_stole_r   <= 1'b0;
        pend_target_r  <= next_ch_r;
      end else begin
        pend_started_r <= 1'b1;
        pend_stole_r   <= 1'b1;
        pend_target_r  <= oldest_w[CHANNELS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ch_r <= '0;
    end else if (commit && pend_started_r && !pend_stole_r) begin
      next_ch_r <= (next_ch_r == IW'(CHANNELS - 1)) ? '0 : next_ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (commit) begin
      busy_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {pend_stole_r, 6'(pend_target_r), pend_started_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SVA_NEXT(a_accept_blocks, accept, !in_tready)
  `SVA_NEXT(a_commit_frees, commit, in_tready && out_tvalid)
  `SVA_IMPLIES(a_pend_busy, pend_valid_r || tail.valid, busy_r)
  `SVA_NEVER(a_ptr_range, 32'(next_ch_r) >= CHANNELS)
  `SVA_IMPLIES(a_suppress_clean, pend_valid_r && !pend_started_r,
               !pend_stole_r && (pend_target_r == '0))

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sva_pkg::*;

  localparam int NCH = 16;
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // no register behind this index
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 8;
  localparam int PHASE_PLAYS = 250;

  // one result beat, laid out as out_tdata
  typedef struct packed {
    logic       stole;
    logic [5:0] channel;
    logic       started;
  } play_res_t;

  class voice_scoreboard;
    logic [7:0]  gap_cfg;
    logic [15:0] delay_cfg;
    logic [6:0]  same_cfg;
    logic [15:0] slot_clip[NCH];
    logic [7:0]  slot_vol[NCH];
    logic [31:0] slot_start[NCH];
    int unsigned rr_next;
    play_res_t   expected[$];
    int          errors;

    function new();
      gap_cfg = GAP_RESET;
      delay_cfg = DELAY_RESET;
      same_cfg = MAX_SAME_RESET;
      for (int i = 0; i < NCH; i++) begin
        slot_clip[i] = '0;
        slot_vol[i] = '0;
        slot_start[i] = '0;
      end
      rr_next = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MIN_VOLUME_GAP: begin
          gap_cfg = val[7:0];
        end
        CFG_MIN_REPEAT_DELAY: begin
          delay_cfg = val;
        end
        CFG_MAX_SAME_CLIP: begin
          same_cfg = val[6:0];
        end
        default: begin
        end
      endcase
    endfunction

    // works out the channel choice for one accepted request
    function void note_request(req_t r);
      int unsigned same_cnt;
      int          oldest_idx;
      int          slot;
      logic [7:0]  vdiff;
      logic [31:0] age;
      play_res_t   res;
      same_cnt = 0;
      oldest_idx = 0;
      res = '0;
      for (int i = 0; i < NCH; i++) begin
        if (slot_clip[i] != r.clip_id) continue;
        vdiff = (slot_vol[i] > r.volume) ? slot_vol[i] - r.volume : r.volume - slot_vol[i];
        age = r.now_ms - slot_start[i];
        if (vdiff < gap_cfg && age < {16'd0, delay_cfg}) begin
          expected.push_back(res);
          return;
        end
        // oldest by raw start time, lowest index on a tie
        if (same_cnt == 0 || slot_start[oldest_idx] > slot_start[i]) oldest_idx = i;
        same_cnt++;
      end
      if (same_cnt <= same_cfg) begin
        slot = rr_next;
        rr_next = (rr_next + 1) % NCH;
        res.stole = 1'b0;
      end else begin
        slot = oldest_idx;
        res.stole = 1'b1;
      end
      slot_clip[slot] = r.clip_id;
      slot_vol[slot] = r.volume;
      slot_start[slot] = r.now_ms;
      res.started = 1'b1;
      res.channel = 6'(slot);
      expected.push_back(res);
    endfunction

    function void check_result(play_res_t got);
      play_res_t want;
      if (expected.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h", $time, got);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.started !== want.started) begin
        $display("%0t: started expected %0d got %0d", $time, want.started, got.started);
        errors++;
      end
      if (got.channel !== want.channel) begin
        $display("%0t: channel expected %0d got %0d", $time, want.channel, got.channel);
        errors++;
      end
      if (got.stole !== want.stole) begin
        $display("%0t: stole_same_clip expected %0d got %0d", $time, want.stole, got.stole);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // clip_id[15:0], volume[23:16], now_ms[55:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // started[0], channel[6:1], stole_same_clip[7]
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  voice_scoreboard sb;
  bit          idle_on;
  bit          long_hold;
  int unsigned quiet;
  logic [15:0] clip_pool[4];
  logic [31:0] time_ms;
  logic [7:0]  last_vol;
  int unsigned cur_delay;

  sound_voice_allocator #(.CHANNELS(NCH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (!idle_on) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : gap_len();
  endfunction

  function automatic req_t mk_play(logic [15:0] clip, logic [7:0] vol, logic [31:0] t);
    req_t r;
    r.clip_id = clip;
    r.volume = vol;
    r.now_ms = t;
    return r;
  endfunction

  // mostly a few clips replayed on a running clock, the rest noise
  function automatic req_t next_play();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.clip_id = clip_pool[$urandom_range(0, 3)];
      time_ms = time_ms + $urandom_range(0, 2 * cur_delay + 4);
      r.now_ms = time_ms;
      case ($urandom_range(0, 2))
        0: r.volume = 8'($urandom_range(0, 128));
        1: r.volume = 8'(last_vol + $urandom_range(0, 40) - 20);
        default: r.volume = 8'($urandom_range(0, 255));
      endcase
    end else begin
      r.clip_id = 16'($urandom());
      r.volume = 8'($urandom());
      r.now_ms = $urandom();
      if (pick < 90) r.clip_id = clip_pool[$urandom_range(0, 3)];
    end
    last_vol = r.volume;
    return r;
  endfunction

  task automatic send_play(req_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {r.now_ms, r.volume, r.clip_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic setup_phase(int ph);
    logic [7:0]  gap_v;
    logic [15:0] delay_v;
    logic [6:0]  same_v;
    case (ph)
      0: begin
        gap_v = 8'd0;
        delay_v = 16'hFFFF;
        same_v = 7'd0;
      end
      1: begin
        gap_v = 8'd128;
        delay_v = 16'd0;
        same_v = 7'd64;
      end
      2: begin
        gap_v = 8'd255;
        delay_v = 16'hFFFF;
        same_v = 7'd127;
      end
      3: begin
        gap_v = 8'd128;
        delay_v = 16'hFFFF;
        same_v = 7'd1;
      end
      default: begin
        gap_v = 8'($urandom_range(0, 128));
        delay_v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom());
        same_v = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64))
                                             : 7'($urandom_range(0, 4));
      end
    endcase
    // upper wdata bits beyond the register width are dropped
    set_reg(CFG_MIN_VOLUME_GAP, {8'($urandom()), gap_v});
    set_reg(CFG_MIN_REPEAT_DELAY, delay_v);
    set_reg(CFG_MAX_SAME_CLIP, {9'($urandom()), same_v});
    if (ph == 3) set_reg(CFG_UNUSED, 16'($urandom()));
    cur_delay = 32'(delay_v);
    for (int k = 0; k < 4; k++) begin
      clip_pool[k] = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    end
    time_ms = $urandom();
    idle_on = (ph % 3) != 2;
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) sb.check_result(play_res_t'(out_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    sb = new();
    quiet = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    cur_delay = 50;
    last_vol = '0;
    time_ms = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: defaults gap 16, delay 50, limit 2
    send_play(mk_play(16'd5, 8'd100, 32'd1000));
    send_play(mk_play(16'd5, 8'd100, 32'd1010));     // recent and similar: dropped
    send_play(mk_play(16'd5, 8'd120, 32'd1020));
    send_play(mk_play(16'd5, 8'd60, 32'd1030));
    send_play(mk_play(16'd5, 8'd10, 32'd1040));      // over the limit: reuse oldest
    send_play(mk_play(16'd0, 8'd0, 32'd0));          // clip zero hits the empty channels
    send_play(mk_play(16'd0, 8'd200, 32'd5));        // steal among equal start times
    send_play(mk_play(16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send_play(mk_play(16'hFFFF, 8'hFF, 32'h0000_0010));  // age wraps past zero
    send_play(mk_play(16'hFFFF, 8'd128, 32'h0000_0020));
    send_play(mk_play(16'hFFFF, 8'd130, 32'h0000_0030));
    send_play(mk_play(16'd7, 8'd0, 32'hFFFF_FFF0));
    send_play(mk_play(16'd7, 8'd50, 32'h0000_0100));
    send_play(mk_play(16'd7, 8'd100, 32'h0000_0200));
    send_play(mk_play(16'd7, 8'd0, 32'h0000_0300));  // oldest by raw time, not wrapped
    send_play(mk_play(16'h8000, 8'h80, 32'h8000_0000));
    send_play(mk_play(16'h5555, 8'h55, 32'h5555_5555));
    send_play(mk_play(16'hAAAA, 8'hAA, 32'hAAAA_AAAA));
    send_play(mk_play(16'h0001, 8'h01, 32'h7FFF_FFFF));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      setup_phase(ph);
      if (ph == 4) long_hold = 1'b1;
      repeat (PHASE_PLAYS) send_play(next_play());
    end

    drain();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sva_pkg.sv
hw/rtl/sva_cell.sv
hw/rtl/sound_voice_allocator.sv
test/tb.sv
